@@ rtl/dcng_pkg.sv @@
// dcng_pkg: constants, device profiles and sequencer states for the DC blocker,
// noise gate and VAD. No dependencies; used by every file in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package dcng_pkg;

  localparam int FRAME_MAX = 1024;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  // serial divider and square root sizes
  localparam int DIVD_W    = 41;
  localparam int DIVS_W    = 24;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);

  // register indexes on the configuration port
  localparam logic [0:0] REG_MODE_SEL    = 1'd0;
  localparam logic [0:0] REG_MIC_PROFILE = 1'd1;

  // profile codes
  localparam logic [1:0] PROF_NEAR = 2'd0;
  localparam logic [1:0] PROF_BT   = 2'd1;
  localparam logic [1:0] PROF_FAR  = 2'd2;

  // Q0.24 constant rounded half up to Q0.15
  function automatic logic [14:0] q24(input logic [23:0] c);
    logic [24:0] s;
    s = 25'(c) + 25'd256;
    return s[23:9];
  endfunction

  localparam logic [15:0] DC_POLE     = 16'd65208;
  localparam logic [14:0] CLIP_LVL    = q24(24'd16441672);
  localparam logic [14:0] NOISE_RESET = q24(24'd167772);
  localparam logic [3:0]  HANGOVER    = 4'd10;
  localparam logic [12:0] GAIN_UNITY  = 13'd4096;

  typedef struct packed {
    logic [13:0] out_gain;  // Q2.12
    logic [14:0] gate_min;  // Q0.15
    logic [12:0] gate_mul;  // Q1.12
    logic [11:0] gate_low;  // Q0.12
    logic [14:0] sf_min;
    logic [13:0] sf_mul;
    logic [15:0] vad_on_p;  // Q0.16
    logic [14:0] pk_min;
    logic [14:0] pk_mul;
    logic [9:0]  alpha;     // Q0.16
    logic [14:0] n_min;
    logic [14:0] n_max;
  } profile_t;

  // unused code falls back to near-field
  function automatic profile_t profile_of(input logic [1:0] sel);
    profile_t p;
    case (sel)
      PROF_BT: p = '{out_gain: 14'd9011, gate_min: q24(24'd41943), gate_mul: 13'd4710,
                     gate_low: 12'd2130, sf_min: q24(24'd100663), sf_mul: 14'd8192,
                     vad_on_p: 16'd22282, pk_min: q24(24'd117441), pk_mul: 15'd8602,
                     alpha: 10'd524, n_min: q24(24'd16777), n_max: q24(24'd2013266)};
      PROF_FAR: p = '{out_gain: 14'd6963, gate_min: q24(24'd50332), gate_mul: 13'd5325,
                      gate_low: 12'd1434, sf_min: q24(24'd134218), sf_mul: 14'd9626,
                      vad_on_p: 16'd27525, pk_min: q24(24'd167772), pk_mul: 15'd11469,
                      alpha: 10'd655, n_min: q24(24'd16777), n_max: q24(24'd1677722)};
      default: p = '{out_gain: 14'd4096, gate_min: q24(24'd67109), gate_mul: 13'd6758,
                     gate_low: 12'd737, sf_min: q24(24'd201327), sf_mul: 14'd12288,
                     vad_on_p: 16'd34079, pk_min: q24(24'd301990), pk_mul: 15'd16384,
                     alpha: 10'd983, n_min: q24(24'd25166), n_max: q24(24'd1342177)};
    endcase
    return p;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HP_MUL,
    ST_THR_MUL,
    ST_XF_MUL,
    ST_XF_DIV,
    ST_G1_MUL,
    ST_G2_MUL,
    ST_RAW_SQ,
    ST_PROC_SQ,
    ST_RAW_DIV,
    ST_RAW_SQRT,
    ST_PROC_DIV,
    ST_PROC_SQRT,
    ST_SF_MUL,
    ST_PK_MUL,
    ST_PROB_DIV,
    ST_VAD,
    ST_NL_MUL1,
    ST_NL_MUL2,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/dcng_div.sv @@
// dcng_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on dcng_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none

module dcng_div import dcng_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0]    quo;
  logic [DIVS_W-1:0]    rem;
  logic [DIVS_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVS_W:0]      rem_sh;
  logic [DIVS_W+1:0]    trial;
  logic                 ge;

  assign rem_sh = {rem, quo[DIVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, dvs};
  assign ge     = !trial[DIVS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIVD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DIVD_W-2:0], ge};
      rem <= ge ? trial[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

`default_nettype wire

@@ rtl/dcng_isqrt.sv @@
// dcng_isqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on dcng_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none

module dcng_isqrt import dcng_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]    rad;
  logic [ROOT_W-1:0]   acc;
  logic [ROOT_W+2:0]   rem;
  logic [SQ_CNT_W-1:0] cnt;
  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+3:0]   diff;
  logic                ge;

  assign rem_sh = {rem[ROOT_W:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, acc, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign ge     = !diff[ROOT_W+3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= SQ_CNT_W'(ROOT_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      acc <= '0;
    end else if (cnt != '0) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      rem <= ge ? diff[ROOT_W+2:0] : rem_sh;
      acc <= {acc[ROOT_W-2:0], ge};
    end
  end

  assign busy = (cnt != '0);
  assign root = acc;

endmodule

`default_nettype wire

@@ rtl/dc_block_noise_gate_vad_top.sv @@
// dc_block_noise_gate_vad_top: DC blocker, soft noise gate and frame VAD.
// Depends on dcng_pkg, dcng_div and dcng_isqrt.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_wr_en              cfg_addr, cfg_wdata
//   in        in         in_valid / in_ready    sample_in, last_in_frame
//   out       out        out_valid / out_ready  out_sample .. asr_speech
//
// One item at a time. A shared shift-add multiplier (one multiplier bit per
// cycle) does the general products; small constant scalings are combinational.
// sum/n and the speech probability go through the one-bit-a-cycle divider, RMS
// through the serial square root. A frame end adds the mean and root steps;
// custom mode adds the filter and gate on each sample and the VAD at a frame end.
// rst is synchronous; afterwards mode_sel is 1 and profile near-field.
// The result sits in the output register; the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module dc_block_noise_gate_vad_top import dcng_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_addr,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_in,
  input  logic               last_in_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               frame_end,
  output logic [14:0]        raw_rms,
  output logic [15:0]        raw_peak,
  output logic [14:0]        proc_rms,
  output logic [15:0]        proc_peak,
  output logic [14:0]        noise_floor,
  output logic [15:0]        speech_prob,
  output logic               vad_on,
  output logic [31:0]        speech_samples,
  output logic               asr_speech
);

  state_t state, state_next;

  // configuration
  logic       mode_sel;
  logic [1:0] mic_profile;
  profile_t   prof;

  // per-item working registers
  logic signed [15:0] x_r, y_r, hp_r;
  logic               last_r, fe_r;
  logic [15:0]        mag_r;
  logic [17:0]        thr_r;
  logic [12:0]        gain_r;
  logic [14:0]        rr_r, pr_r;
  logic [17:0]        floor_r, pkthr_r;
  logic [15:0]        prob_r;
  logic               vad_r;
  logic [31:0]        np_r;

  // filter, gate, VAD and frame state
  logic signed [15:0] prev_input, prev_highpass;
  logic [14:0]        noise_level;
  logic [3:0]         hangover_left;
  logic [31:0]        speech_total;
  logic [40:0]        raw_sum, proc_sum;
  logic [15:0]        raw_peak_hold, proc_peak_hold;
  logic [CNT_W-1:0]   samples_in_frame;

  // shared serial multiplier
  logic [47:0] mul_a, mul_p;
  logic [15:0] mul_b;
  logic [4:0]  mul_cnt;
  logic        mul_start, mul_busy;
  logic [31:0] mul_a_in;
  logic [15:0] mul_b_in;

  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dvd_in, div_q;
  logic [DIVS_W-1:0] div_dvs_in;
  logic              sq_start, sq_busy;
  logic [RAD_W-1:0]  sq_rad_in;
  logic [ROOT_W-1:0] sq_root;

  logic op_issued, is_op, unit_busy, op_start, op_done, in_acc, out_load;

  assign prof   = profile_of(mic_profile);
  assign in_acc = in_valid && in_ready;

  // ---------------- combinational arithmetic ----------------
  logic [15:0]        abs_x, abs_y, abs_ph, abs_hp;
  logic signed [34:0] hp_diff, hp_sum;
  logic signed [32:0] pole_term;
  logic signed [18:0] hp_wide;
  logic signed [15:0] hp_calc;
  logic [32:0]        r12s;
  logic [17:0]        r12, thr_calc, floor_calc, pk_calc;
  logic               gate_low_rgn, xfade_rgn;
  logic [19:0]        thr3;
  logic [13:0]        gsum;
  logic [12:0]        gain_xf;
  logic signed [42:0] yv, yr;
  logic signed [18:0] yw, clip_pos, clip_neg;
  logic signed [15:0] y_calc;
  logic [21:0]        num_a, num_b, num_mag;
  logic               num_pos;
  logic               now_speech, vad_calc;
  logic [3:0]         hang_next;
  logic [32:0]        spk_sum, nls;
  logic [16:0]        nl;
  logic [14:0]        nl_clamped;
  logic [CNT_W-1:0]   cnt_inc;
  logic               frame_done;

  assign abs_x  = x_r[15] ? 16'(-x_r) : 16'(x_r);
  assign abs_y  = y_r[15] ? 16'(-y_r) : 16'(y_r);
  assign abs_ph = prev_highpass[15] ? 16'(-prev_highpass) : 16'(prev_highpass);
  assign abs_hp = hp_calc[15] ? 16'(-hp_calc) : 16'(hp_calc);

  // DC blocker: (x - x1) + pole * y1, rounded
  always_comb begin
    pole_term = prev_highpass[15] ? -$signed({1'b0, mul_p[31:0]})
                                  : $signed({1'b0, mul_p[31:0]});
    hp_diff   = 35'(x_r) - 35'(prev_input);
    hp_sum    = (hp_diff <<< 16) + 35'(pole_term) + 35'sd32768;
    hp_wide   = hp_sum[34:16];
    if (hp_wide > 19'sd32767)
      hp_calc = 16'sh7FFF;
    else if (hp_wide < -19'sd32768)
      hp_calc = 16'sh8000;
    else
      hp_calc = hp_wide[15:0];
  end

  // noise-scaled thresholds, product shifted down by 12 bits with rounding
  always_comb begin
    r12s       = 33'(mul_p[31:0]) + 33'd2048;
    r12        = r12s[29:12];
    thr_calc   = (r12 >= 18'(prof.gate_min)) ? r12 : 18'(prof.gate_min);
    if (thr_calc == '0)
      thr_calc = 18'd1;
    floor_calc = (r12 >= 18'(prof.sf_min)) ? r12 : 18'(prof.sf_min);
    if (floor_calc == '0)
      floor_calc = 18'd1;
    pk_calc    = (r12 >= 18'(prof.pk_min)) ? r12 : 18'(prof.pk_min);
    gate_low_rgn = {2'b00, mag_r} <= thr_calc;
    xfade_rgn    = 21'({mag_r, 1'b0}) <= 21'(thr_calc) * 21'd5;
  end

  assign thr3 = 20'(thr_r) * 20'd3;

  // crossfade gain, saturated at unity
  always_comb begin
    gsum = 14'(prof.gate_low) + 14'(div_q[12:0]);
    if (div_q[DIVD_W-1:13] != '0 || gsum > 14'(GAIN_UNITY))
      gain_xf = GAIN_UNITY;
    else
      gain_xf = gsum[12:0];
  end

  // output scaling: hp * gain * out_gain, rounded by 24 bits, clipped
  always_comb begin
    yv       = hp_r[15] ? -$signed({2'b00, mul_p[40:0]}) : $signed({2'b00, mul_p[40:0]});
    yr       = yv + 43'sd8388608;
    yw       = yr[42:24];
    clip_pos = 19'(CLIP_LVL);
    clip_neg = -clip_pos;
    if (yw > clip_pos)
      y_calc = 16'(clip_pos);
    else if (yw < clip_neg)
      y_calc = 16'(clip_neg);
    else
      y_calc = yw[15:0];
  end

  // speech probability numerator: 20*rms - 13*floor
  assign num_a   = 22'(pr_r) * 22'd20;
  assign num_b   = 22'(floor_r) * 22'd13;
  assign num_pos = num_a > num_b;
  assign num_mag = num_a - num_b;

  // hangover VAD
  always_comb begin
    now_speech = (prob_r > prof.vad_on_p) && ({2'b00, proc_peak_hold} > pkthr_r);
    if (now_speech)
      hang_next = HANGOVER;
    else if (hangover_left != '0)
      hang_next = hangover_left - 1'b1;
    else
      hang_next = '0;
    vad_calc = now_speech || (hang_next != '0);
    spk_sum  = 33'(speech_total) + 33'(samples_in_frame);
  end

  // noise floor EMA
  always_comb begin
    nls = 33'(np_r) + 33'(mul_p[31:0]) + 33'd32768;
    nl  = nls[32:16];
    if (nl < 17'(prof.n_min))
      nl_clamped = prof.n_min;
    else if (nl > 17'(prof.n_max))
      nl_clamped = prof.n_max;
    else
      nl_clamped = nl[14:0];
  end

  assign cnt_inc    = samples_in_frame + 1'b1;
  assign frame_done = last_r || (cnt_inc >= CNT_W'(FRAME_MAX));

  // ---------------- operation handshake ----------------
  always_comb begin
    is_op     = 1'b1;
    unit_busy = mul_busy;
    unique case (state) inside
      ST_IDLE, ST_VAD, ST_OUT: is_op = 1'b0;
      ST_XF_DIV, ST_RAW_DIV, ST_PROC_DIV, ST_PROB_DIV: unit_busy = div_busy;
      ST_RAW_SQRT, ST_PROC_SQRT: unit_busy = sq_busy;
      default: unit_busy = mul_busy;
    endcase
  end

  assign op_start = is_op && !op_issued;
  assign op_done  = is_op && op_issued && !unit_busy;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_issued <= 1'b0;
    end else if (op_start) begin
      op_issued <= 1'b1;
    end else if (op_done) begin
      op_issued <= 1'b0;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_acc) state_next = mode_sel ? ST_HP_MUL : ST_RAW_SQ;
      ST_HP_MUL:    if (op_done) state_next = ST_THR_MUL;
      ST_THR_MUL: begin
        if (op_done)
          state_next = (!gate_low_rgn && xfade_rgn) ? ST_XF_MUL : ST_G1_MUL;
      end
      ST_XF_MUL:    if (op_done) state_next = ST_XF_DIV;
      ST_XF_DIV:    if (op_done) state_next = ST_G1_MUL;
      ST_G1_MUL:    if (op_done) state_next = ST_G2_MUL;
      ST_G2_MUL:    if (op_done) state_next = ST_RAW_SQ;
      ST_RAW_SQ:    if (op_done) state_next = ST_PROC_SQ;
      ST_PROC_SQ:   if (op_done) state_next = frame_done ? ST_RAW_DIV : ST_OUT;
      ST_RAW_DIV:   if (op_done) state_next = ST_RAW_SQRT;
      ST_RAW_SQRT:  if (op_done) state_next = ST_PROC_DIV;
      ST_PROC_DIV:  if (op_done) state_next = ST_PROC_SQRT;
      ST_PROC_SQRT: if (op_done) state_next = mode_sel ? ST_SF_MUL : ST_OUT;
      ST_SF_MUL:    if (op_done) state_next = ST_PK_MUL;
      ST_PK_MUL:    if (op_done) state_next = num_pos ? ST_PROB_DIV : ST_VAD;
      ST_PROB_DIV:  if (op_done) state_next = ST_VAD;
      ST_VAD:       state_next = vad_calc ? ST_OUT : ST_NL_MUL1;
      ST_NL_MUL1:   if (op_done) state_next = ST_NL_MUL2;
      ST_NL_MUL2:   if (op_done) state_next = ST_OUT;
      ST_OUT:       if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ---------------- unit starts and operands ----------------
  always_comb begin
    in_ready   = (state == ST_IDLE);
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_dvd_in = '0;
    div_dvs_in = '0;
    sq_rad_in  = '0;
    unique case (state)
      ST_HP_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(abs_ph);
        mul_b_in  = DC_POLE;
      end
      ST_THR_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(noise_level);
        mul_b_in  = 16'(prof.gate_mul);
      end
      ST_XF_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(18'({2'b00, mag_r}) - thr_r);
        mul_b_in  = 16'({13'(GAIN_UNITY - 13'(prof.gate_low)), 1'b0});
      end
      ST_XF_DIV: begin
        div_start  = op_start;
        div_dvd_in = 41'(mul_p[31:0]) + 41'(thr3 >> 1);
        div_dvs_in = 24'(thr3);
      end
      ST_G1_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(mag_r);
        mul_b_in  = 16'(gain_r);
      end
      ST_G2_MUL: begin
        mul_start = op_start;
        mul_a_in  = mul_p[31:0];
        mul_b_in  = 16'(prof.out_gain);
      end
      ST_RAW_SQ: begin
        mul_start = op_start;
        mul_a_in  = 32'(abs_x);
        mul_b_in  = abs_x;
      end
      ST_PROC_SQ: begin
        mul_start = op_start;
        mul_a_in  = 32'(abs_y);
        mul_b_in  = abs_y;
      end
      ST_RAW_DIV: begin
        div_start  = op_start;
        div_dvd_in = raw_sum;
        div_dvs_in = 24'(samples_in_frame);
      end
      ST_PROC_DIV: begin
        div_start  = op_start;
        div_dvd_in = proc_sum;
        div_dvs_in = 24'(samples_in_frame);
      end
      ST_RAW_SQRT, ST_PROC_SQRT: begin
        sq_start  = op_start;
        sq_rad_in = div_q[RAD_W-1:0];
      end
      ST_SF_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(noise_level);
        mul_b_in  = 16'(prof.sf_mul);
      end
      ST_PK_MUL: begin
        mul_start = op_start;
        mul_a_in  = 32'(noise_level);
        mul_b_in  = 16'(prof.pk_mul);
      end
      ST_PROB_DIV: begin
        div_start  = op_start;
        div_dvd_in = 41'({num_mag, 16'h0000});
        div_dvs_in = 24'(24'(floor_r) * 24'd27);
      end
      ST_NL_MUL1: begin
        mul_start = op_start;
        mul_a_in  = 32'(noise_level);
        mul_b_in  = 16'(17'h10000 - 17'(prof.alpha));
      end
      ST_NL_MUL2: begin
        mul_start = op_start;
        mul_a_in  = 32'(pr_r);
        mul_b_in  = 16'(prof.alpha);
      end
      default: ;
    endcase
  end

  // ---------------- shift-add multiplier ----------------
  assign mul_busy = (mul_cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (mul_start) begin
      mul_cnt <= 5'd16;
    end else if (mul_busy) begin
      mul_cnt <= mul_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a <= 48'(mul_a_in);
      mul_b <= mul_b_in;
      mul_p <= '0;
    end else if (mul_busy) begin
      if (mul_b[0])
        mul_p <= mul_p + mul_a;
      mul_a <= {mul_a[46:0], 1'b0};
      mul_b <= {1'b0, mul_b[15:1]};
    end
  end

  dcng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd_in),
    .divisor  (div_dvs_in),
    .busy     (div_busy),
    .quotient (div_q)
  );

  dcng_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad_in),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode_sel  <= 1'b1;
      mic_profile <= PROF_NEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MODE_SEL:    mode_sel    <= cfg_wdata[0];
          REG_MIC_PROFILE: mic_profile <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // ---------------- filter, gate and frame state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_input       <= '0;
      prev_highpass    <= '0;
      noise_level      <= NOISE_RESET;
      hangover_left    <= '0;
      speech_total     <= '0;
      raw_sum          <= '0;
      proc_sum         <= '0;
      raw_peak_hold    <= '0;
      proc_peak_hold   <= '0;
      samples_in_frame <= '0;
    end else begin
      if (state == ST_HP_MUL && op_done) begin
        prev_input    <= x_r;
        prev_highpass <= hp_calc;
      end
      if (state == ST_RAW_SQ && op_done)
        raw_sum <= raw_sum + 41'(mul_p[31:0]);
      if (state == ST_PROC_SQ && op_done) begin
        proc_sum         <= proc_sum + 41'(mul_p[31:0]);
        raw_peak_hold    <= (abs_x > raw_peak_hold) ? abs_x : raw_peak_hold;
        proc_peak_hold   <= (abs_y > proc_peak_hold) ? abs_y : proc_peak_hold;
        samples_in_frame <= cnt_inc;
      end
      if (state == ST_VAD) begin
        hangover_left <= hang_next;
        if (now_speech)
          speech_total <= spk_sum[32] ? 32'hFFFF_FFFF : spk_sum[31:0];
      end
      if (state == ST_NL_MUL2 && op_done)
        noise_level <= nl_clamped;
      // frame statistics restart once the frame result is registered
      if (out_load && fe_r) begin
        raw_sum          <= '0;
        proc_sum         <= '0;
        raw_peak_hold    <= '0;
        proc_peak_hold   <= '0;
        samples_in_frame <= '0;
      end
    end
  end

  // ---------------- per-item payload ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= sample_in;
      last_r <= last_in_frame;
      if (!mode_sel)
        y_r <= sample_in;
    end
    if (op_done) begin
      unique case (state)
        ST_HP_MUL: begin
          hp_r  <= hp_calc;
          mag_r <= abs_hp;
        end
        ST_THR_MUL: begin
          thr_r <= thr_calc;
          if (gate_low_rgn)
            gain_r <= 13'(prof.gate_low);
          else if (!xfade_rgn)
            gain_r <= GAIN_UNITY;
        end
        ST_XF_DIV:    gain_r  <= gain_xf;
        ST_G2_MUL:    y_r     <= y_calc;
        ST_PROC_SQ:   fe_r    <= frame_done;
        ST_RAW_SQRT:  rr_r    <= sq_root[15] ? 15'h7FFF : sq_root[14:0];
        ST_PROC_SQRT: pr_r    <= sq_root[15] ? 15'h7FFF : sq_root[14:0];
        ST_SF_MUL:    floor_r <= floor_calc;
        ST_PK_MUL: begin
          pkthr_r <= pk_calc;
          if (!num_pos)
            prob_r <= '0;
        end
        ST_PROB_DIV:  prob_r  <= (div_q[DIVD_W-1:16] != '0) ? 16'hFFFF : div_q[15:0];
        ST_NL_MUL1:   np_r    <= mul_p[31:0];
        default: ;
      endcase
    end
    if (state == ST_VAD)
      vad_r <= vad_calc;
    // fields beyond the sample are zero except on a frame end
    if (out_load) begin
      out_sample     <= y_r;
      frame_end      <= fe_r;
      raw_rms        <= fe_r ? rr_r : '0;
      raw_peak       <= fe_r ? raw_peak_hold : '0;
      proc_rms       <= fe_r ? pr_r : '0;
      proc_peak      <= fe_r ? proc_peak_hold : '0;
      noise_floor    <= fe_r ? noise_level : '0;
      speech_prob    <= (fe_r && mode_sel) ? prob_r : '0;
      vad_on         <= fe_r && mode_sel && vad_r;
      speech_samples <= fe_r ? speech_total : '0;
      asr_speech     <= fe_r && (mode_sel ? vad_r : 1'b1);
    end
  end

  // ---------------- assertions ----------------
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> (mul_cnt == '0))
    else $error("multiplier restarted while busy");

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    samples_in_frame <= CNT_W'(FRAME_MAX))
    else $error("frame sample count overran");

  a_hangover_bound: assert property (@(posedge clk) disable iff (rst)
    hangover_left <= HANGOVER)
    else $error("hangover count out of range");

  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_level != '0)
    else $error("noise floor collapsed to zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !out_ready) |=> (state == ST_OUT && out_valid))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
